// ===== sv/jsd_pkg.sv =====
// Shared constants for the Jensen-Shannon pairwise distance core.
// No dependencies; imported by the core, jsd_div and jsd_log (jsd_sqrt does not import it).
package jsd_pkg;

    // Fixed-point layout
    localparam int FRAC_BITS = 24;
    localparam int PROB_W    = 25;   // Q1.24 probability, value up to 1.0
    localparam int MIX_W     = 26;   // Q2.24 mixture p + q
    localparam int LOG_W     = 30;   // signed Q6.24 log2
    localparam int COUNT_W   = 32;   // one matrix entry

    // Register file
    localparam int ROWS_CFG_W = 9;
    localparam int COLS_CFG_W = 4;
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // Result fields
    localparam int COL_OUT_W = 3;
    localparam int DIST_W    = 16;
    localparam logic [DIST_W-1:0] DIST_MAX = 16'hFFFF;

endpackage

// ===== sv/jensen_shannon_pairwise_distance_core.sv =====
// Jensen-Shannon pairwise distance core: one loaded beat per cycle while s_tvalid is high, then
// one column's zero-sum check per cycle; a zero sum gives a single error result. Each row of
// each pair runs two divisions, three log2 steps (a zero operand skips normalization and
// squaring) and a multiply-accumulate; each pair adds a square root and an output beat that
// is held under backpressure. No input is taken during the pair phase.
// Reset (aresetn, sync, active low) clears sequencer, sums, load position and restores config; store not cleared.
module jensen_shannon_pairwise_distance_core
    import jsd_pkg::*;
#(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLUMNS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] count_value
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] first_column, [5:3] second_column, [21:6] distance
    output logic        m_tuser,   // [0] error_flag
    output logic        m_tlast,   // last_result
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int MEM_D = MAX_COLUMNS << RW;
    localparam int SUM_W = COUNT_W + RW;
    localparam int TW    = 60;
    localparam int AW    = 36 + RW;
    localparam int SQ_IN = AW + 7;
    localparam int SQ_W  = SQ_IN + (SQ_IN % 2);
    localparam int HW    = SQ_W / 2;

    localparam logic [ROWS_CFG_W-1:0] ROWS_RST = ROWS_CFG_W'((MAX_ROWS < 256) ? MAX_ROWS : 256);
    localparam logic [COLS_CFG_W-1:0] COLS_RST = COLS_CFG_W'((MAX_COLUMNS < 8) ? MAX_COLUMNS : 8);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_CHK   = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_DWAIT = 4'd4;
    localparam logic [3:0] S_LOG   = 4'd5;
    localparam logic [3:0] S_LWAIT = 4'd6;
    localparam logic [3:0] S_MUL   = 4'd7;
    localparam logic [3:0] S_ADD   = 4'd8;
    localparam logic [3:0] S_ROW   = 4'd9;
    localparam logic [3:0] S_SQ    = 4'd10;
    localparam logic [3:0] S_SWAIT = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    localparam logic [1:0] SEL_P = 2'd0;
    localparam logic [1:0] SEL_Q = 2'd1;
    localparam logic [1:0] SEL_M = 2'd2;

    logic [3:0]            state_reg;
    logic [ROWS_CFG_W-1:0] rows_reg;
    logic [COLS_CFG_W-1:0] cols_reg;
    logic [RW-1:0]         row_reg;
    logic [CW-1:0]         col_reg;
    logic [SUM_W-1:0]      sums_reg [MAX_COLUMNS];
    logic [CW-1:0]         i_reg;
    logic [CW-1:0]         j_reg;
    logic                  half_reg;
    logic [1:0]            sel_reg;
    logic [PROB_W-1:0]     p_reg;
    logic [PROB_W-1:0]     q_reg;
    logic signed [LOG_W-1:0] lp_reg;
    logic signed [LOG_W-1:0] lq_reg;
    logic signed [LOG_W-1:0] lm_reg;
    logic signed [56:0]    prod_reg;
    logic signed [TW-1:0]  t_reg;
    logic signed [AW-1:0]  acc_reg;
    logic [COUNT_W-1:0]    store_mem [MEM_D];
    logic [COUNT_W-1:0]    rd_reg;
    logic                  m_tvalid_reg;
    logic [COL_OUT_W-1:0]  first_reg;
    logic [COL_OUT_W-1:0]  second_reg;
    logic [DIST_W-1:0]     dist_reg;
    logic                  err_reg;
    logic                  last_reg;

    logic                  cfg_wr;
    logic [CW-1:0]         sum_sel;
    logic [SUM_W-1:0]      sum_rd;
    logic [CW+RW-1:0]      wr_addr;
    logic [CW+RW-1:0]      rd_addr;
    logic [MIX_W-1:0]      m_w;
    logic [MIX_W-1:0]      log_in;
    logic signed [26:0]    mul_a;
    logic signed [LOG_W-1:0] mul_b;
    logic                  s_acc;
    logic                  last_row;
    logic                  last_col;
    logic                  last_pair;
    logic [ROWS_CFG_W-1:0] rows_wr;
    logic [COLS_CFG_W-1:0] cols_wr;
    logic [SQ_W-1:0]       sq_in;

    logic                  div_done;
    logic [PROB_W-1:0]     div_quo;
    logic                  log_done;
    logic signed [LOG_W-1:0] log_res;
    logic                  sq_done;
    logic [HW-1:0]         sq_root;

    // handshakes
    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign s_tready = (state_reg == S_LOAD);
    assign s_acc    = s_tvalid & s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, dist_reg, second_reg, first_reg};
    assign m_tuser  = err_reg;
    assign m_tlast  = last_reg;
    assign prdata   = (paddr[2] == REG_ROWS) ? 32'(rows_reg) : 32'(cols_reg);

    // register write values, saturated into range
    always_comb begin
        rows_wr = pwdata[ROWS_CFG_W-1:0];
        if (rows_wr == '0) begin
            rows_wr = ROWS_CFG_W'(1);
        end else if (32'(rows_wr) > MAX_ROWS) begin
            rows_wr = ROWS_CFG_W'(MAX_ROWS);
        end
        cols_wr = pwdata[COLS_CFG_W-1:0];
        if (cols_wr < COLS_CFG_W'(2)) begin
            cols_wr = COLS_CFG_W'(2);
        end else if (32'(cols_wr) > MAX_COLUMNS) begin
            cols_wr = COLS_CFG_W'(MAX_COLUMNS);
        end
    end

    // position and operand selection
    always_comb begin
        last_row  = (32'(row_reg) + 1 == 32'(rows_reg));
        last_col  = (32'(col_reg) + 1 == 32'(cols_reg));
        last_pair = (32'(i_reg) + 2 == 32'(cols_reg)) && (32'(j_reg) + 1 == 32'(cols_reg));
        sum_sel   = (state_reg == S_LOAD) ? col_reg : (half_reg ? j_reg : i_reg);
        sum_rd    = sums_reg[sum_sel];
        wr_addr   = {col_reg, row_reg};
        rd_addr   = {(half_reg ? j_reg : i_reg), row_reg};
        m_w       = MIX_W'(p_reg) + MIX_W'(q_reg);
        unique case (sel_reg)
            SEL_P:   log_in = MIX_W'(p_reg);
            SEL_Q:   log_in = MIX_W'(q_reg);
            default: log_in = m_w;
        endcase
        unique case (sel_reg)
            SEL_P: begin
                mul_a = $signed(27'(p_reg));
                mul_b = lp_reg;
            end
            SEL_Q: begin
                mul_a = $signed(27'(q_reg));
                mul_b = lq_reg;
            end
            default: begin
                mul_a = $signed(27'(m_w));
                mul_b = lm_reg;
            end
        endcase
        sq_in = (acc_reg > 0) ? SQ_W'({acc_reg, 7'b0}) : '0;
    end

    // matrix store
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            store_mem[wr_addr] <= s_tdata;
        end
        rd_reg <= store_mem[rd_addr];
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            rows_reg     <= ROWS_RST;
            cols_reg     <= COLS_RST;
            row_reg      <= '0;
            col_reg      <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            half_reg     <= 1'b0;
            sel_reg      <= SEL_P;
            acc_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            for (int c = 0; c < MAX_COLUMNS; c++) begin
                sums_reg[c] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == REG_ROWS) begin
                    rows_reg <= rows_wr;
                end else begin
                    cols_reg <= cols_wr;
                end
                row_reg <= '0;
                col_reg <= '0;
                for (int c = 0; c < MAX_COLUMNS; c++) begin
                    sums_reg[c] <= '0;
                end
            end
            unique case (state_reg)
                S_LOAD: begin
                    if (s_acc) begin
                        sums_reg[col_reg] <= sum_rd + SUM_W'(s_tdata);
                        if (last_row && last_col) begin
                            i_reg     <= '0;
                            state_reg <= S_CHK;
                        end else if (last_row) begin
                            row_reg <= '0;
                            col_reg <= col_reg + CW'(1);
                        end else begin
                            row_reg <= row_reg + RW'(1);
                        end
                    end
                end
                S_CHK: begin
                    if (sum_rd == '0) begin
                        first_reg    <= '0;
                        second_reg   <= '0;
                        dist_reg     <= '0;
                        err_reg      <= 1'b1;
                        last_reg     <= 1'b1;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_OUT;
                    end else if (32'(i_reg) + 1 == 32'(cols_reg)) begin
                        i_reg     <= '0;
                        j_reg     <= CW'(1);
                        row_reg   <= '0;
                        acc_reg   <= '0;
                        half_reg  <= 1'b0;
                        state_reg <= S_RD;
                    end else begin
                        i_reg <= i_reg + CW'(1);
                    end
                end
                S_RD:  state_reg <= S_DIV;
                S_DIV: state_reg <= S_DWAIT;
                S_DWAIT: begin
                    if (div_done) begin
                        if (!half_reg) begin
                            p_reg     <= div_quo;
                            half_reg  <= 1'b1;
                            state_reg <= S_RD;
                        end else begin
                            q_reg     <= div_quo;
                            half_reg  <= 1'b0;
                            sel_reg   <= SEL_P;
                            state_reg <= S_LOG;
                        end
                    end
                end
                S_LOG: state_reg <= S_LWAIT;
                S_LWAIT: begin
                    if (log_done) begin
                        unique case (sel_reg)
                            SEL_P:   lp_reg <= log_res;
                            SEL_Q:   lq_reg <= log_res;
                            default: lm_reg <= log_res;
                        endcase
                        if (sel_reg == SEL_M) begin
                            sel_reg   <= SEL_P;
                            state_reg <= S_MUL;
                        end else begin
                            sel_reg   <= sel_reg + 2'd1;
                            state_reg <= S_LOG;
                        end
                    end
                end
                // shared multiplier, one product per pass
                S_MUL: begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_ADD;
                end
                S_ADD: begin
                    unique case (sel_reg)
                        SEL_P:   t_reg <= $signed(TW'({m_w, {FRAC_BITS{1'b0}}}))
                                          + TW'(prod_reg);
                        SEL_Q:   t_reg <= t_reg + TW'(prod_reg);
                        default: t_reg <= t_reg - TW'(prod_reg);
                    endcase
                    if (sel_reg == SEL_M) begin
                        sel_reg   <= SEL_P;
                        state_reg <= S_ROW;
                    end else begin
                        sel_reg   <= sel_reg + 2'd1;
                        state_reg <= S_MUL;
                    end
                end
                // floor to Q.24 and accumulate
                S_ROW: begin
                    acc_reg <= acc_reg + AW'(t_reg >>> FRAC_BITS);
                    if (last_row) begin
                        state_reg <= S_SQ;
                    end else begin
                        row_reg   <= row_reg + RW'(1);
                        state_reg <= S_RD;
                    end
                end
                S_SQ: state_reg <= S_SWAIT;
                S_SWAIT: begin
                    if (sq_done) begin
                        first_reg    <= COL_OUT_W'(i_reg);
                        second_reg   <= COL_OUT_W'(j_reg);
                        dist_reg     <= (sq_root > HW'(DIST_MAX)) ? DIST_MAX
                                                                 : sq_root[DIST_W-1:0];
                        err_reg      <= 1'b0;
                        last_reg     <= last_pair;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        if (last_reg) begin
                            row_reg   <= '0;
                            col_reg   <= '0;
                            i_reg     <= '0;
                            for (int c = 0; c < MAX_COLUMNS; c++) begin
                                sums_reg[c] <= '0;
                            end
                            state_reg <= S_LOAD;
                        end else begin
                            if (32'(j_reg) + 1 == 32'(cols_reg)) begin
                                i_reg <= i_reg + CW'(1);
                                j_reg <= i_reg + CW'(2);
                            end else begin
                                j_reg <= j_reg + CW'(1);
                            end
                            row_reg   <= '0;
                            acc_reg   <= '0;
                            half_reg  <= 1'b0;
                            state_reg <= S_RD;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    jsd_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == S_DIV),
        .num     (rd_reg),
        .den     (sum_rd),
        .done    (div_done),
        .quo     (div_quo)
    );

    jsd_log u_log (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == S_LOG),
        .v       (log_in),
        .done    (log_done),
        .res     (log_res)
    );

    jsd_sqrt #(
        .SQ_W (SQ_W)
    ) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == S_SQ),
        .x       (sq_in),
        .done    (sq_done),
        .root    (sq_root)
    );

endmodule

// ===== sv/jsd_div.sv =====
// Serial restoring divider: quo = floor(num * 2^24 / den), one bit per cycle.
// Requires num <= den and den > 0. Depends on jsd_pkg.
module jsd_div
    import jsd_pkg::*;
#(
    parameter int SUM_W = 40
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [COUNT_W-1:0]   num,
    input  logic [SUM_W-1:0]     den,
    output logic                 done,
    output logic [PROB_W-1:0]    quo
);

    logic [SUM_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  den_reg;
    logic [PROB_W-1:0] nb_reg;
    logic [PROB_W-1:0] q_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [SUM_W:0] r2;
    logic [SUM_W:0] diff;
    logic           ge;

    // one trial subtract per cycle
    always_comb begin
        r2   = {rem_reg, nb_reg[PROB_W-1]};
        diff = r2 - {1'b0, den_reg};
        ge   = (r2 >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                // top 31 numerator bits are below den, so no quotient bit there
                rem_reg  <= SUM_W'(num >> 1);
                nb_reg   <= {num[0], {(PROB_W-1){1'b0}}};
                den_reg  <= den;
                cnt_reg  <= 5'(PROB_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[SUM_W-1:0] : r2[SUM_W-1:0];
                nb_reg  <= {nb_reg[PROB_W-2:0], 1'b0};
                q_reg   <= {q_reg[PROB_W-2:0], ge};
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

// ===== sv/jsd_log.sv =====
// Iterative fixed-point log2 unit: normalize one bit per cycle, then
// 24 squaring rounds, one fraction bit each; a zero input returns 0. Depends on jsd_pkg.
module jsd_log
    import jsd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [MIX_W-1:0]        v,
    output logic                    done,
    output logic signed [LOG_W-1:0] res
);

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_NORM = 2'd1;
    localparam logic [1:0] L_SQ   = 2'd2;
    localparam logic [1:0] L_FIN  = 2'd3;

    logic [1:0]           phase_reg;
    logic [31:0]          y_reg;
    logic [4:0]           e_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic [4:0]           cnt_reg;
    logic                 done_reg;
    logic [LOG_W-1:0]     res_reg;

    logic [61:0] sq;
    logic [31:0] yn;

    // squaring of the Q1.30 mantissa
    always_comb begin
        sq = y_reg[30:0] * y_reg[30:0];
        yn = sq[61:30];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                L_IDLE: begin
                    if (start) begin
                        if (v == '0) begin
                            res_reg  <= '0;
                            done_reg <= 1'b1;
                        end else begin
                            y_reg     <= 32'(v);
                            e_reg     <= 5'd30;
                            phase_reg <= L_NORM;
                        end
                    end
                end
                L_NORM: begin
                    if (y_reg[30]) begin
                        cnt_reg   <= 5'(FRAC_BITS);
                        phase_reg <= L_SQ;
                    end else begin
                        y_reg <= {y_reg[30:0], 1'b0};
                        e_reg <= e_reg - 5'd1;
                    end
                end
                L_SQ: begin
                    y_reg    <= yn[31] ? {1'b0, yn[31:1]} : yn;
                    frac_reg <= {frac_reg[FRAC_BITS-2:0], yn[31]};
                    cnt_reg  <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd1) begin
                        phase_reg <= L_FIN;
                    end
                end
                L_FIN: begin
                    res_reg   <= {6'(e_reg) - 6'd24, frac_reg};
                    done_reg  <= 1'b1;
                    phase_reg <= L_IDLE;
                end
                default: phase_reg <= L_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign res  = $signed(res_reg);

endmodule

// ===== sv/jsd_sqrt.sv =====
// Digit-by-digit integer square root, two radicand bits per cycle.
// No package dependencies.
module jsd_sqrt #(
    parameter int SQ_W = 52
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [SQ_W-1:0]     x,
    output logic                done,
    output logic [SQ_W/2-1:0]   root
);

    localparam int HW   = SQ_W / 2;
    localparam int CNTW = $clog2(HW + 1);

    logic [SQ_W-1:0] x_reg;
    logic [HW:0]     rem_reg;
    logic [HW-1:0]   root_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [HW+2:0] rs;
    logic [HW+2:0] trial;
    logic [HW+2:0] diff;
    logic          ge;

    always_comb begin
        rs    = {rem_reg, x_reg[SQ_W-1:SQ_W-2]};
        trial = {1'b0, root_reg, 2'b01};
        diff  = rs - trial;
        ge    = (rs >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg    <= x;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= CNTW'(HW);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                x_reg    <= {x_reg[SQ_W-3:0], 2'b00};
                rem_reg  <= ge ? diff[HW:0] : rs[HW:0];
                root_reg <= {root_reg[HW-2:0], ge};
                cnt_reg  <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
